@@ sv/skmh_pkg.sv @@
package skmh_pkg;

    localparam int DATA_W     = 32;
    localparam int KEEP_W     = 5;
    localparam int K_MAX_DEF  = 16;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN,
        S_POP_RD,
        S_POP_EMIT,
        S_POP_LAST
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic              last;
    } emit_t;

endpackage

@@ sv/skmh_ram.sv @@
module skmh_ram #(
    parameter int DEPTH = skmh_pkg::K_MAX_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = skmh_pkg::DATA_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/skmh_ctrl.sv @@
module skmh_ctrl #(
    parameter int K_MAX = skmh_pkg::K_MAX_DEF,
    parameter int CW    = $clog2(K_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_take,
    input  logic [skmh_pkg::DATA_W-1:0]   value,
    input  logic                          is_final,
    input  logic [CW-1:0]                 k,
    input  logic                          out_free,
    output logic                          idle,
    output skmh_pkg::emit_t               emit
);

    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int LW = IW + 2;
    localparam int DW = skmh_pkg::DATA_W;

    skmh_pkg::state_t state_reg, state_next;

    logic [CW-1:0] held_reg, held_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [DW-1:0] best_val_reg, best_val_next;
    logic [DW-1:0] cur_reg, cur_next;
    logic          fin_reg, fin_next;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;

    logic [DW-1:0] cmp_a, cmp_b;
    logic          gt;
    logic [LW-1:0] l_ext, r_ext, held_ext;
    logic [IW-1:0] parent;
    logic          l_ok, r_ok, take_r, emit_now;

    skmh_ram #(
        .DEPTH (K_MAX),
        .AW    (IW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared signed comparator: a > b
    always_comb
    begin
        unique case (state_reg)
            skmh_pkg::S_UP_CMP:
            begin
                cmp_a = cur_reg;
                cmp_b = rd_data;
            end
            skmh_pkg::S_DN_CMP:
            begin
                cmp_a = rd_data;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = rd_data;
                cmp_b = cur_reg;
            end
        endcase
    end

    assign gt       = $signed(cmp_a) > $signed(cmp_b);
    assign l_ext    = {1'b0, idx_reg, 1'b1};
    assign r_ext    = l_ext + LW'(1);
    assign held_ext = LW'(held_reg);
    assign parent   = (idx_reg - IW'(1)) >> 1;
    assign l_ok     = l_ext < held_ext;
    assign r_ok     = r_ext < held_ext;
    assign take_r   = r_ok && gt;
    assign emit_now = held_reg <= k;
    assign idle     = state_reg == skmh_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skmh_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    priority if (held_reg < k)
                        state_next = skmh_pkg::S_UP_RD;
                    else if (held_reg != '0)
                        state_next = skmh_pkg::S_ROOT_RD;
                    else
                        state_next = skmh_pkg::S_FIN;
                end
            end
            skmh_pkg::S_UP_RD:
                state_next = (idx_reg == '0) ? skmh_pkg::S_FIN : skmh_pkg::S_UP_CMP;
            skmh_pkg::S_UP_CMP:
                state_next = gt ? skmh_pkg::S_UP_RD : skmh_pkg::S_FIN;
            skmh_pkg::S_ROOT_RD:
                state_next = skmh_pkg::S_ROOT_CMP;
            skmh_pkg::S_ROOT_CMP:
                state_next = gt ? skmh_pkg::S_DN_RDL : skmh_pkg::S_FIN;
            skmh_pkg::S_DN_RDL:
                state_next = l_ok ? skmh_pkg::S_DN_RDR : skmh_pkg::S_FIN;
            skmh_pkg::S_DN_RDR:
                state_next = skmh_pkg::S_DN_CMP;
            skmh_pkg::S_DN_CMP:
                state_next = (take_r || best_idx_reg != idx_reg) ?
                             skmh_pkg::S_DN_RDL : skmh_pkg::S_FIN;
            skmh_pkg::S_FIN:
                state_next = (fin_reg && held_reg != '0) ?
                             skmh_pkg::S_POP_RD : skmh_pkg::S_IDLE;
            skmh_pkg::S_POP_RD:
                state_next = skmh_pkg::S_POP_EMIT;
            skmh_pkg::S_POP_EMIT:
            begin
                if (!emit_now || out_free)
                    state_next = skmh_pkg::S_POP_LAST;
            end
            skmh_pkg::S_POP_LAST:
                state_next = skmh_pkg::S_DN_RDL;
            default:
                state_next = skmh_pkg::S_IDLE;
        endcase
    end

    // hole-based sifting: cur_reg is the value travelling through the heap
    always_comb
    begin
        held_next     = held_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        cur_next      = cur_reg;
        fin_next      = fin_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = cur_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        emit.valid    = 1'b0;
        emit.value    = rd_data;
        emit.last     = held_reg == CW'(1);
        unique case (state_reg)
            skmh_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    cur_next = value;
                    fin_next = is_final;
                    if (held_reg < k)
                    begin
                        idx_next  = held_reg[IW-1:0];
                        held_next = held_reg + CW'(1);
                    end
                end
            end
            skmh_pkg::S_UP_RD:
            begin
                if (idx_reg == '0)
                    wr_en = 1'b1;
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            skmh_pkg::S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (gt)
                begin
                    wr_data  = rd_data;
                    idx_next = parent;
                end
            end
            skmh_pkg::S_ROOT_RD:
                rd_en = 1'b1;
            skmh_pkg::S_ROOT_CMP:
                idx_next = '0;
            skmh_pkg::S_DN_RDL:
            begin
                if (l_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = l_ext[IW-1:0];
                end
                else
                    wr_en = 1'b1;
            end
            skmh_pkg::S_DN_RDR:
            begin
                if (gt)
                begin
                    best_idx_next = l_ext[IW-1:0];
                    best_val_next = rd_data;
                end
                else
                begin
                    best_idx_next = idx_reg;
                    best_val_next = cur_reg;
                end
                if (r_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_ext[IW-1:0];
                end
            end
            skmh_pkg::S_DN_CMP:
            begin
                wr_en = 1'b1;
                priority if (take_r)
                begin
                    wr_data  = rd_data;
                    idx_next = r_ext[IW-1:0];
                end
                else if (best_idx_reg != idx_reg)
                begin
                    wr_data  = best_val_reg;
                    idx_next = best_idx_reg;
                end
                else
                    wr_data = cur_reg;
            end
            skmh_pkg::S_FIN:
            begin
            end
            skmh_pkg::S_POP_RD:
                rd_en = 1'b1;
            skmh_pkg::S_POP_EMIT:
            begin
                // top sits in rd_data until the last entry is fetched
                if (!emit_now || out_free)
                begin
                    emit.valid = emit_now;
                    held_next  = held_reg - CW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = IW'(held_reg - CW'(1));
                end
            end
            skmh_pkg::S_POP_LAST:
            begin
                cur_next = rd_data;
                idx_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skmh_pkg::S_IDLE;
            held_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        cur_reg      <= cur_next;
    end

endmodule

@@ sv/smallest_k_max_heap_select.sv @@
// Smallest-k selector. Signed values arrive on the input channel (value,
// is_final); the k smallest of a run are kept in a max-heap held in a small
// RAM, k being keep_count saturated to K_MAX. keep_count is written through
// keep_count_we/keep_count; the user must do so only while the block is idle,
// as the block itself does not enforce this; it resets to 1. Input transfer:
// in_valid high and in_stall low. in_stall is high while an element is being
// processed; the next transfer lands on the edge after it drops. Work after
// a transfer: insert reads and compares/writes each parent visited, writes
// the root if it climbs to the top and closes; replace reads and compares
// the top, closes at once if it stays, else descends level by level (read
// left, read right, compare/write), ends in a leaf write or a compare that
// moves nothing, then closes. The single RAM read port and the shared
// comparator serialise these steps. On the element marked is_final the heap
// is drained largest first: each pop reads the top, emits it, fetches the last
// entry, sifts the moved entry down and closes; pops beyond k leave no result.
// Results go through an output register (out_valid, kept_value, last_result);
// the final result of a run carries last_result. While out_stall holds the
// register full, draining pauses and the payload stays put. After reset the
// heap is empty, no result is pending and keep_count is 1.
module smallest_k_max_heap_select #(
    parameter int K_MAX = skmh_pkg::K_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 keep_count_we,
    input  logic [skmh_pkg::KEEP_W-1:0]          keep_count,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [skmh_pkg::DATA_W-1:0]   value,
    input  logic                                 is_final,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [skmh_pkg::DATA_W-1:0]   kept_value,
    output logic                                 last_result
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int KW = (CW > skmh_pkg::KEEP_W) ? CW : skmh_pkg::KEEP_W;

    logic [skmh_pkg::KEEP_W-1:0] keep_reg;
    logic [KW-1:0]               keep_ext;
    logic [CW-1:0]               k;
    logic                        idle, in_take, out_free;
    skmh_pkg::emit_t             emit;

    logic                        out_valid_reg, out_valid_next;
    logic [skmh_pkg::DATA_W-1:0] kept_value_reg, kept_value_next;
    logic                        last_result_reg, last_result_next;

    assign keep_ext = KW'(keep_reg);
    assign k        = (keep_ext > KW'(K_MAX)) ? CW'(K_MAX) : CW'(keep_ext);
    assign in_stall = !idle;
    assign in_take  = in_valid && idle;
    assign out_free = !out_valid_reg || !out_stall;

    skmh_ctrl #(
        .K_MAX (K_MAX),
        .CW    (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .value    (value),
        .is_final (is_final),
        .k        (k),
        .out_free (out_free),
        .idle     (idle),
        .emit     (emit)
    );

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        kept_value_next  = kept_value_reg;
        last_result_next = last_result_reg;
        if (emit.valid)
        begin
            out_valid_next   = 1'b1;
            kept_value_next  = emit.value;
            last_result_next = emit.last;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= skmh_pkg::KEEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (keep_count_we)
                keep_reg <= keep_count;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_value_reg  <= kept_value_next;
        last_result_reg <= last_result_next;
    end

    assign out_valid   = out_valid_reg;
    assign kept_value  = kept_value_reg;
    assign last_result = last_result_reg;

endmodule
